// File: rtl/isortcc_pkg.sv
// Shared types and constants for the insertion sort with compare count.
// No dependencies; used by isortcc_cell and the top level.
`default_nettype none
package isortcc_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;
      logic pop;
   } ctrl_type;

endpackage
`default_nettype wire

// File: rtl/isortcc_cell.sv
// One compare-and-shift cell of the sorting chain.
// Depends on isortcc_pkg for the value width and the command struct.
`default_nettype none
module isortcc_cell (
   input  wire                                  clock,
   input  wire isortcc_pkg::ctrl_type           ctrl,
   input  wire                                  occupied,
   input  wire signed [isortcc_pkg::VALUE_W-1:0] new_value,
   input  wire signed [isortcc_pkg::VALUE_W-1:0] left_value,
   input  wire                                  left_greater,
   input  wire signed [isortcc_pkg::VALUE_W-1:0] right_value,
   output logic signed [isortcc_pkg::VALUE_W-1:0] value,
   output logic                                 greater,
   output logic                                 land
);

   logic signed [isortcc_pkg::VALUE_W-1:0] value_ff;
   logic signed [isortcc_pkg::VALUE_W-1:0] value_in;

   // An empty cell counts as greater, so equal values stay in front (stable)
   assign greater = !occupied || (value_ff > new_value);
   assign land    = greater && !left_greater;
   assign value   = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert && greater) begin
         value_in = left_greater ? left_value : new_value;
      end else if (ctrl.pop) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

// File: rtl/insertion_sort_with_compare_count.sv
// Streaming insertion sort over a chain of CAPACITY compare-and-shift cells.
// A stored request's value is inserted into the chain in ST_IDLE (every cell
// compares against it and shifts right in parallel), and the comparison count
// is updated in ST_COUNT, from the registered landing position. A request
// that arrives while the chain is full is dropped and flagged. A request marked
// final is followed by one response per stored value, smallest first, one per cycle
// while rsp_stall is low, as the chain shifts towards cell 0;
// compare_total and overflowed are the same on every response and end_of_run
// marks the last one. No requests are taken while responses are being delivered.
// Depends on isortcc_pkg and isortcc_cell.
`default_nettype none
module insertion_sort_with_compare_count #(
   parameter int CAPACITY = 64
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire signed [isortcc_pkg::VALUE_W-1:0]  req_value,
   input  wire                                    req_is_final,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic signed [isortcc_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic [isortcc_pkg::COUNT_W-1:0]        rsp_compare_total,
   output logic                                   rsp_overflowed,
   output logic                                   rsp_end_of_run
);

   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int SUM_W  = ((FILL_W > isortcc_pkg::COUNT_W) ? FILL_W
                                                           : isortcc_pkg::COUNT_W) + 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_COUNT = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic [FILL_W-1:0]                fill_ff, fill_in;
   logic [isortcc_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                             overflow_ff, overflow_in;
   logic                             final_ff, final_in;
   logic [CAPACITY-1:0]              land_ff, land_in;

   isortcc_pkg::ctrl_type            ctrl;
   logic signed [isortcc_pkg::VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]              greater;
   logic [CAPACITY-1:0]              land;
   logic [CAPACITY-1:0]              occupied;

   logic [IDX_W-1:0]                 pos;
   logic [FILL_W-1:0]                cmp;
   logic [SUM_W-1:0]                 sum;
   logic [isortcc_pkg::COUNT_W-1:0]  count_sat;
   logic                             req_accept;

   // ---------------------------------------------------------------- chain
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [isortcc_pkg::VALUE_W-1:0] left_value;
         logic signed [isortcc_pkg::VALUE_W-1:0] right_value;
         logic                                   left_greater;

         assign occupied[gi] = (fill_ff > FILL_W'(gi));

         if (gi == 0) begin : g_head
            assign left_value   = req_value;
            assign left_greater = 1'b0;
         end else begin : g_body
            assign left_value   = cell_value[gi-1];
            assign left_greater = greater[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_tail
            assign right_value = cell_value[gi];
         end else begin : g_inner
            assign right_value = cell_value[gi+1];
         end

         isortcc_cell u_cell (
            .clock        (clock),
            .ctrl         (ctrl),
            .occupied     (occupied[gi]),
            .new_value    (req_value),
            .left_value   (left_value),
            .left_greater (left_greater),
            .right_value  (right_value),
            .value        (cell_value[gi]),
            .greater      (greater[gi]),
            .land         (land[gi])
         );
      end
   endgenerate

   // ------------------------------------------------------- compare count
   // Landing flags are one-hot; OR the indices together to get the position
   always_comb begin
      pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (land_ff[i]) begin
            pos = pos | IDX_W'(i);
         end
      end
   end

   // larger elements passed, plus the stop compare unless it ran off the front
   assign cmp = fill_ff - FILL_W'(pos) + FILL_W'(pos != '0);
   assign sum = SUM_W'(count_ff) + SUM_W'(cmp);
   assign count_sat = (sum > SUM_W'(isortcc_pkg::COUNT_MAX)) ? isortcc_pkg::COUNT_MAX
                                                           : sum[isortcc_pkg::COUNT_W-1:0];

   // ------------------------------------------------------------- control
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      final_in    = final_ff;
      land_in     = land_ff;
      ctrl.insert = 1'b0;
      ctrl.pop    = 1'b0;
      rsp_valid   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (fill_ff < FILL_W'(CAPACITY)) begin
                  ctrl.insert = 1'b1;
                  land_in     = land;
                  final_in    = req_is_final;
                  state_in    = ST_COUNT;
               end else begin
                  overflow_in = 1'b1;
                  if (req_is_final) begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_COUNT: begin
            count_in = count_sat;
            fill_in  = fill_ff + FILL_W'(1);
            state_in = final_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               ctrl.pop = 1'b1;
               fill_in  = fill_ff - FILL_W'(1);
               if (fill_ff == FILL_W'(1)) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         final_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         final_ff    <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      land_ff <= land_in;
   end

   assign rsp_sorted_value  = cell_value[0];
   assign rsp_compare_total = count_ff;
   assign rsp_overflowed    = overflow_ff;
   assign rsp_end_of_run    = (fill_ff == FILL_W'(1));

endmodule
`default_nettype wire
